// File: rtl/core/rsa_pkg.sv
// Shared types and constants for the record sort-by-average block.
// No dependencies; imported by rsa_ctrl, rsa_dp and record_sort_by_average.
package rsa_pkg;

  localparam int unsigned MAX_RECORDS_DEF = 64;

  localparam int unsigned ROLL_W = 16;
  localparam int unsigned MARK_W = 8;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned REC_W  = ROLL_W + KEY_W;
  localparam int unsigned SUM_W  = MARK_W + 2;

  // floor(sum / 3) == (sum * 683) >> 11 for every sum up to 765
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_MUL_W = 11;
  localparam int unsigned DIV3_SHIFT = 11;
  localparam int unsigned PROD_W     = SUM_W + DIV3_MUL_W;

  typedef struct packed {
    logic store;      // write incoming record
    logic scan_clr;   // restart a minimum search pass
    logic scan_rd;    // read next stored entry
    logic emit_done;  // current minimum taken by the sink
    logic batch_clr;  // run finished, empty the store
  } dp_cmd_t;

  typedef struct packed {
    logic issue_last; // read pointer at the last stored entry
    logic run_end;    // the record on output is the last of the run
  } dp_sts_t;

endpackage

// File: rtl/core/rsa_ctrl.sv
// Controller FSM for the record sort-by-average block.
// Depends on rsa_pkg; drives the handshakes and the datapath commands.
module rsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rsa_pkg::dp_sts_t  sts,
  output rsa_pkg::dp_cmd_t  cmd
);
  import rsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.store = 1'b1;
          if (in_tlast) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready) begin
          cmd.emit_done = 1'b1;
          if (sts.run_end) begin
            cmd.batch_clr = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= (state_nxt == ST_IDLE);
      out_tvalid_r <= (state_nxt == ST_EMIT);
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready_r && out_tvalid_r))
    else $error("input and output open together");

  a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tready && sts.run_end) |=> in_tready_r)
    else $error("no return to collect after final result");

endmodule

// File: rtl/core/rsa_dp.sv
// Datapath for the record sort-by-average block: key unit, record memory,
// minimum search over the stored records and output registers. Uses rsa_pkg.
module rsa_dp #(
  parameter int unsigned MAX_RECORDS = rsa_pkg::MAX_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsa_pkg::dp_cmd_t              cmd,
  output rsa_pkg::dp_sts_t              sts,
  input  logic [rsa_pkg::ROLL_W-1:0]    roll_number,
  input  logic [rsa_pkg::MARK_W-1:0]    mark_a,
  input  logic [rsa_pkg::MARK_W-1:0]    mark_b,
  input  logic [rsa_pkg::MARK_W-1:0]    mark_c,
  output logic [rsa_pkg::ROLL_W-1:0]    out_roll_number,
  output logic [rsa_pkg::KEY_W-1:0]     out_average,
  output logic                          out_last,
  output logic                          overflowed
);
  import rsa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  logic [REC_W-1:0]   mem [MAX_RECORDS];

  logic [CW-1:0]      count_r;
  logic               ovf_r;
  logic [CW-1:0]      rd_ptr_r;
  logic [REC_W-1:0]   rd_data_r;
  logic [AW-1:0]      rd_idx_r;
  logic               rd_vld_r;
  logic               prev_vld_r;
  logic [KEY_W-1:0]   prev_key_r;
  logic [AW-1:0]      prev_idx_r;
  logic [CW-1:0]      out_cnt_r;
  logic               best_vld_r;
  logic [REC_W-1:0]   best_rec_r;
  logic [AW-1:0]      best_idx_r;

  logic [SUM_W-1:0]   sum;
  logic [PROD_W-1:0]  prod;
  logic [KEY_W-1:0]   avg;
  logic [REC_W-1:0]   new_rec;
  logic               has_room;
  logic               fresh;
  logic               take;
  logic [CW-1:0]      last_pos;

  assign sum  = SUM_W'(mark_a) + SUM_W'(mark_b) + SUM_W'(mark_c);
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
  assign avg  = prod[DIV3_SHIFT +: KEY_W];
  assign new_rec  = {roll_number, avg};
  assign has_room = (count_r < CW'(MAX_RECORDS));
  assign last_pos = count_r - CW'(1);

  // records already emitted sort at or before the last {key, index} taken
  assign fresh = !prev_vld_r || (rd_data_r[KEY_W-1:0] > prev_key_r) ||
                 ((rd_data_r[KEY_W-1:0] == prev_key_r) && (rd_idx_r > prev_idx_r));

  // strict compare keeps the earliest record among equal keys
  assign take = rd_vld_r && fresh &&
                (!best_vld_r || (rd_data_r[KEY_W-1:0] < best_rec_r[KEY_W-1:0]));

  always_ff @(posedge clk) begin
    if (cmd.store && has_room) begin
      mem[count_r[AW-1:0]] <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_ptr_r[AW-1:0]];
    rd_idx_r  <= rd_ptr_r[AW-1:0];
    if (take) begin
      best_rec_r <= rd_data_r;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.emit_done) begin
      prev_key_r <= best_rec_r[KEY_W-1:0];
      prev_idx_r <= best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      rd_ptr_r   <= '0;
      rd_vld_r   <= 1'b0;
      prev_vld_r <= 1'b0;
      out_cnt_r  <= '0;
      best_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.store) begin
        if (has_room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.scan_clr) begin
        rd_ptr_r   <= '0;
        best_vld_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          rd_ptr_r <= rd_ptr_r + CW'(1);
        end
        if (take) begin
          best_vld_r <= 1'b1;
        end
      end
      if (cmd.batch_clr) begin
        count_r    <= '0;
        ovf_r      <= 1'b0;
        prev_vld_r <= 1'b0;
        out_cnt_r  <= '0;
      end else if (cmd.emit_done) begin
        prev_vld_r <= 1'b1;
        out_cnt_r  <= out_cnt_r + CW'(1);
      end
    end
  end

  assign sts.issue_last = (rd_ptr_r == last_pos);
  assign sts.run_end    = (out_cnt_r == last_pos);

  assign out_roll_number = best_rec_r[REC_W-1:KEY_W];
  assign out_average     = best_rec_r[KEY_W-1:0];
  assign out_last        = sts.run_end;
  assign overflowed      = ovf_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RECORDS))
    else $error("record count above capacity");

  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_done |-> best_vld_r &&
      (!prev_vld_r || (best_rec_r[KEY_W-1:0] >= prev_key_r)))
    else $error("emitting without a fresh minimum");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_done |-> (out_cnt_r < count_r))
    else $error("more results than stored records");

endmodule

// File: rtl/core/record_sort_by_average.sv
// Top level of the record sort-by-average block.
// Depends on rsa_pkg, rsa_ctrl and rsa_dp.
//
//  channel | dir | data                                     | end marker
//  in_*    | in  | roll_number, mark_a, mark_b, mark_c      | in_tlast = final record
//  out_*   | out | roll_number, average; tuser = overflowed | out_tlast = last result
//
// Collect: one record per cycle while in_tready is high.
// Output: for a run of n records each result takes one search pass over
//   the record memory (n reads, one port), then the SETTLE and EMIT states;
//   in_tready is back the cycle after the last result.
// Reset: synchronous, rst_n low; the record memory itself is not cleared.
// Stalls: out_tready low holds the current result; no input is taken then.
module record_sort_by_average #(
  parameter int unsigned MAX_RECORDS = rsa_pkg::MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] roll_number, [23:16] mark_a, [31:24] mark_b, [39:32] mark_c
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] roll_number, [23:16] average
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  // [0] overflowed
  output logic        out_tuser
);
  import rsa_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [ROLL_W-1:0]  res_roll;
  logic [KEY_W-1:0]   res_avg;

  rsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rsa_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .roll_number     (in_tdata[15:0]),
    .mark_a          (in_tdata[23:16]),
    .mark_b          (in_tdata[31:24]),
    .mark_c          (in_tdata[39:32]),
    .out_roll_number (res_roll),
    .out_average     (res_avg),
    .out_last        (out_tlast),
    .overflowed      (out_tuser)
  );

  assign out_tdata = {res_avg, res_roll};

endmodule

// File: dv/tb_record_sort_by_average.sv
// Testbench for record_sort_by_average: streams batches of records, predicts the
// stably sorted result items of each batch and checks every result field.
// Depends on rsa_pkg and the record_sort_by_average RTL.
module tb_record_sort_by_average;
  import rsa_pkg::*;

  localparam int unsigned CAPACITY      = MAX_RECORDS_DEF;
  localparam int unsigned MARKS_PER_REC = 3;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          PRINT_LIMIT   = 100;

  typedef struct packed {
    logic [ROLL_W-1:0] roll;
    logic [KEY_W-1:0]  avg;
  } stored_rec_t;

  typedef struct packed {
    logic [ROLL_W-1:0] roll;
    logic [KEY_W-1:0]  avg;
    logic              last;
    logic              dropped;
  } sorted_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  stored_rec_t  batch_q[$];
  logic         batch_dropped = 1'b0;
  sorted_item_t sorted_q[$];

  int mismatches = 0;
  int sent_items = 0;
  int cycles     = 0;
  bit idle_en    = 1'b1;
  int hold_len   = 0;
  int hold_req   = 0;
  int hold_ack   = 0;
  int hold_left  = 0;
  int sink_gap   = 0;

  record_sort_by_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL record_sort_by_average");
      $finish;
    end
  end

  // stores the record while there is room; on a final item, emits the batch in stable key order
  function automatic void store_and_sort(logic [ROLL_W-1:0] roll, logic [MARK_W-1:0] a,
                                         logic [MARK_W-1:0] b, logic [MARK_W-1:0] c,
                                         logic fin);
    stored_rec_t      order_q[$];
    stored_rec_t      rec;
    logic [SUM_W-1:0] sum;
    int               j;
    sum = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    rec.roll = roll;
    rec.avg  = KEY_W'(sum / MARKS_PER_REC);
    if (batch_q.size() < CAPACITY) batch_q.push_back(rec);
    else batch_dropped = 1'b1;
    if (!fin) return;
    foreach (batch_q[i]) begin
      j = order_q.size();
      while (j > 0 && order_q[j-1].avg > batch_q[i].avg) j--;
      order_q.insert(j, batch_q[i]);
    end
    foreach (order_q[i])
      sorted_q.push_back('{order_q[i].roll, order_q[i].avg,
                           i == order_q.size() - 1, batch_dropped});
    batch_q.delete();
    batch_dropped = 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // result item transfers at the rising edge after this sample point
  always @(negedge clk) begin
    sorted_item_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("result item with none pending", 32'(out_tdata), 32'd0);
      end else begin
        want = sorted_q.pop_front();
        if (out_tdata[15:0] !== want.roll)
          report_mismatch("roll_number", 32'(out_tdata[15:0]), 32'(want.roll));
        if (out_tdata[23:16] !== want.avg)
          report_mismatch("average", 32'(out_tdata[23:16]), 32'(want.avg));
        if (out_tlast !== want.last)
          report_mismatch("tlast", 32'(out_tlast), 32'(want.last));
        if (out_tuser !== want.dropped)
          report_mismatch("overflowed", 32'(out_tuser), 32'(want.dropped));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap   <= sink_gap - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      sink_gap   <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // leaves tvalid high; callers lower it before letting time pass
  task automatic send_record(logic [ROLL_W-1:0] roll, logic [MARK_W-1:0] a,
                             logic [MARK_W-1:0] b, logic [MARK_W-1:0] c, logic fin);
    bit taken;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c, b, a, roll};
    in_tlast  <= fin;
    do begin
      @(negedge clk);
      taken = (in_tready === 1'b1);
      @(posedge clk);
    end while (!taken);
    store_and_sort(roll, a, b, c, fin);
    sent_items++;
  endtask

  task automatic send_batch(int count, int spread);
    int base;
    base = $urandom_range(0, 255 - spread);
    for (int i = 0; i < count; i++)
      send_record(ROLL_W'($urandom),
                  MARK_W'(base + $urandom_range(0, spread)),
                  MARK_W'(base + $urandom_range(0, spread)),
                  MARK_W'(base + $urandom_range(0, spread)),
                  i == count - 1);
  endtask

  task automatic drain_runs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sorted_q.size() != 0);
  endtask

  task automatic request_sink_hold(int len);
    in_tvalid <= 1'b0;
    @(negedge clk);
    hold_len = len;
    hold_req++;
    @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_record('0, '0, '0, '0, 1'b1);
    send_record('1, '1, '1, '1, 1'b1);
    send_record(16'h1234, 8'd255, 8'd0, 8'd0, 1'b1);
    send_record(16'hA5C3, 8'd0, 8'd255, 8'd254, 1'b1);
    drain_runs();
  endtask

  task automatic test_stable_ties();
    send_record(16'd1, 8'd5, 8'd5, 8'd5, 1'b0);
    send_record(16'd2, 8'd4, 8'd5, 8'd6, 1'b0);
    send_record(16'd3, 8'd3, 8'd3, 8'd3, 1'b0);
    send_record(16'd4, 8'd5, 8'd5, 8'd7, 1'b0);
    send_record(16'd5, 8'd0, 8'd0, 8'd0, 1'b0);
    send_record(16'd6, 8'd255, 8'd255, 8'd255, 1'b0);
    send_record(16'd7, 8'd2, 8'd3, 8'd4, 1'b0);
    send_record(16'd8, 8'd255, 8'd255, 8'd254, 1'b0);
    send_record(16'd9, 8'd2, 8'd2, 8'd1, 1'b0);
    send_record(16'd10, 8'd1, 8'd1, 8'd0, 1'b1);
    send_record(16'd20, 8'd200, 8'd200, 8'd200, 1'b0);
    send_record(16'd21, 8'd10, 8'd10, 8'd11, 1'b1);
    drain_runs();
  endtask

  // exactly full, then one past full so the final record itself is dropped
  task automatic test_capacity();
    send_batch(CAPACITY, 3);
    send_batch(CAPACITY + 1, 255);
    drain_runs();
  endtask

  task automatic test_backpressure();
    send_batch(12, 255);
    request_sink_hold(300);
    send_batch(8, 3);
    drain_runs();
  endtask

  task automatic test_random_runs();
    int goal;
    int size;
    goal = sent_items + 200;
    while (sent_items < goal) begin
      case ($urandom_range(0, 11))
        0:       size = $urandom_range(20, CAPACITY + 2);
        1, 2:    size = 1;
        default: size = $urandom_range(2, 10);
      endcase
      send_batch(size, ($urandom_range(0, 2) == 0) ? 3 : 255);
    end
    drain_runs();
  endtask

  task automatic test_quiet_tail();
    idle_en = 1'b0;
    repeat (6) send_batch($urandom_range(2, 10), 255);
    drain_runs();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_stable_ties();
    test_capacity();
    test_backpressure();
    test_random_runs();
    test_quiet_tail();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("PASS record_sort_by_average");
    else $display("FAIL record_sort_by_average");
    $finish;
  end

endmodule
